FILE: rtl/image_rotate_nearest_macros.svh
// Assertion macros shared by the rotation datapath.
`ifndef IMAGE_ROTATE_NEAREST_MACROS_SVH
`define IMAGE_ROTATE_NEAREST_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define IRN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("image_rotate_nearest: assertion failed");
// Check that a condition never holds outside reset.
`define IRN_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("image_rotate_nearest: forbidden condition seen");
`else
`define IRN_ASSERT(lbl, clk, rstn, prop)
`define IRN_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: rtl/irn_pkg.sv
`default_nettype none

package irn_pkg;

  // Frame store geometry
  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(FRAME_WORDS);

  // Field widths
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COLOR_W    = 3 * CHAN_W;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Datapath widths: delta is 2*coord - size, sum is the Q.15 source coordinate
  localparam int unsigned DELTA_W = SIZE_W + 2;
  localparam int unsigned PROD_W  = DELTA_W + ANGLE_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned Q_SHIFT = 14;
  localparam int unsigned FRAC_W  = Q_SHIFT + 1;
  localparam int unsigned SRC_W   = SUM_W - FRAC_W;
  localparam logic [FRAC_W-1:0] RND_HALF = FRAC_W'(1) << (FRAC_W - 1);

  // Register reset values
  localparam logic [SIZE_W-1:0]         RST_WIDTH  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0]         RST_HEIGHT = SIZE_W'(256);
  localparam logic signed [ANGLE_W-1:0] RST_COS    = ANGLE_W'(16384);
  localparam logic signed [ANGLE_W-1:0] RST_SIN    = '0;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PRODUCE = 1'b1
  } op_e;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 8'd0,
    REG_HEIGHT = 8'd1,
    REG_COS    = 8'd2,
    REG_SIN    = 8'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULT,
    S_SUM,
    S_ROUND,
    S_READ,
    S_EMIT
  } back_state_e;

  typedef struct packed {
    op_e               operation;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  blue_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  red_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;
    logic              out_of_bounds;
  } res_t;

  typedef struct packed {
    logic [IDX_W-1:0]      reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  // Live configuration seen by front and back
  typedef struct packed {
    logic [SIZE_W-1:0]         eff_w;
    logic [SIZE_W-1:0]         eff_h;
    logic signed [ANGLE_W-1:0] cos_angle;
    logic signed [ANGLE_W-1:0] sin_angle;
  } ctrl_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic                      is_load;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic [COLOR_W-1:0]        color;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } qent_t;

endpackage

`default_nettype wire

FILE: rtl/irn_channels_if.sv
`default_nettype none

interface irn_pix_if import irn_pkg::*; ();
  logic    valid;
  logic    ready;
  pix_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface irn_res_if import irn_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface irn_cfg_if import irn_pkg::*; ();
  logic    valid;
  logic    ready;
  cfg_wr_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/irn_queue.sv
`default_nettype none
`include "image_rotate_nearest_macros.svh"

module irn_queue import irn_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire qent_t push_ent_i,
  output logic       pop_valid_o,
  input  wire logic  pop_i,
  output qent_t      pop_ent_o
);

  qent_t             ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_ent_o    = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_ent_i;
    end
  end

  `IRN_ASSERT_NEVER(a_q_overfill, clk_i, rst_ni, count_q > QCNT_W'(QUEUE_DEPTH))
  `IRN_ASSERT(a_q_grow, clk_i, rst_ni, push && !pop |=> count_q == $past(count_q) + 1'b1)
  `IRN_ASSERT(a_q_shrink, clk_i, rst_ni, pop && !push |=> count_q == $past(count_q) - 1'b1)

endmodule

`default_nettype wire

FILE: rtl/irn_front.sv
`default_nettype none

module irn_front import irn_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire ctrl_t   ctrl_i,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire pix_in_t in_word_i,
  output logic         push_valid_o,
  input  wire logic    push_ready_i,
  output qent_t        push_ent_o
);

  logic  hold_q, hold_d;
  qent_t ent_q, ent_d;
  logic  keep;

  assign in_ready_o   = !hold_q || push_ready_i;
  assign push_valid_o = hold_q;
  assign push_ent_o   = ent_q;

  // Drop loads that fall outside the frame store
  assign keep = (in_word_i.operation == OP_PRODUCE) ||
                ((32'(in_word_i.pixel_x) < MAX_WIDTH) &&
                 (32'(in_word_i.pixel_y) < MAX_HEIGHT));

  always_comb begin
    hold_d = hold_q && !push_ready_i;
    ent_d  = ent_q;
    if (in_valid_i && in_ready_o) begin
      hold_d        = keep;
      ent_d.is_load = (in_word_i.operation == OP_LOAD);
      ent_d.x       = in_word_i.pixel_x;
      ent_d.y       = in_word_i.pixel_y;
      ent_d.color   = {in_word_i.red_in, in_word_i.green_in, in_word_i.blue_in};
      ent_d.dx      = $signed({{(DELTA_W - COORD_W - 1){1'b0}}, in_word_i.pixel_x, 1'b0}) -
                      $signed({{(DELTA_W - SIZE_W){1'b0}}, ctrl_i.eff_w});
      ent_d.dy      = $signed({{(DELTA_W - COORD_W - 1){1'b0}}, in_word_i.pixel_y, 1'b0}) -
                      $signed({{(DELTA_W - SIZE_W){1'b0}}, ctrl_i.eff_h});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

FILE: rtl/irn_back.sv
`default_nettype none
`include "image_rotate_nearest_macros.svh"

module irn_back import irn_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctrl_t ctrl_i,
  input  wire logic  pop_valid_i,
  output logic       pop_o,
  input  wire qent_t ent_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output res_t       out_word_o
);

  back_state_e state_q, state_d;

  logic signed [DELTA_W-1:0] dx_q, dy_q;
  logic signed [PROD_W-1:0]  p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [SUM_W-1:0]   nx_q, ny_q;
  logic signed [SUM_W-1:0]   nx_d, ny_d, w_term, h_term;
  logic                      oob_q;
  logic [ADDR_W-1:0]         rd_addr_q, rd_addr_d, wr_addr;
  logic [COLOR_W-1:0]        rd_data_q, color_sel;
  logic [COLOR_W-1:0]        frame_mem [FRAME_WORDS];

  logic signed [SRC_W-1:0] qx, qy, sx, sy;
  logic [FRAC_W-1:0]       rx, ry;
  logic                    upx, upy, in_img;

  logic out_valid_q, out_valid_d;
  res_t out_q;
  logic take, mem_we, out_free, out_load;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (pop_valid_i && !ent_i.is_load) state_d = S_MULT;
      S_MULT:  state_d = S_SUM;
      S_SUM:   state_d = S_ROUND;
      S_ROUND: state_d = S_READ;
      S_READ:  state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    take     = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE:  take = pop_valid_i;
      S_EMIT:  out_load = out_free;
      default: ;
    endcase
    mem_we = take && ent_i.is_load;
  end

  assign pop_o = take;

  // Center offsets folded back in, scaled to Q.15
  assign w_term = $signed({{(SUM_W - SIZE_W - Q_SHIFT){1'b0}}, ctrl_i.eff_w, {Q_SHIFT{1'b0}}});
  assign h_term = $signed({{(SUM_W - SIZE_W - Q_SHIFT){1'b0}}, ctrl_i.eff_h, {Q_SHIFT{1'b0}}});
  assign nx_d   = SUM_W'(p_xc_q) + SUM_W'(p_ys_q) + w_term;
  assign ny_d   = SUM_W'(p_yc_q) - SUM_W'(p_xs_q) + h_term;

  // Round to nearest, ties to even
  always_comb begin
    qx  = nx_q[SUM_W-1:FRAC_W];
    qy  = ny_q[SUM_W-1:FRAC_W];
    rx  = nx_q[FRAC_W-1:0];
    ry  = ny_q[FRAC_W-1:0];
    upx = (rx > RND_HALF) || ((rx == RND_HALF) && qx[0]);
    upy = (ry > RND_HALF) || ((ry == RND_HALF) && qy[0]);
    sx  = qx + SRC_W'(upx);
    sy  = qy + SRC_W'(upy);
    in_img = (sx >= 0) && (sx < $signed({{(SRC_W - SIZE_W){1'b0}}, ctrl_i.eff_w})) &&
             (sy >= 0) && (sy < $signed({{(SRC_W - SIZE_W){1'b0}}, ctrl_i.eff_h}));
    rd_addr_d = ADDR_W'(32'(sy[SIZE_W-1:0]) * MAX_WIDTH + 32'(sx[SIZE_W-1:0]));
  end

  assign wr_addr   = ADDR_W'(32'(ent_i.y) * MAX_WIDTH + 32'(ent_i.x));
  assign color_sel = oob_q ? '0 : rd_data_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dx_q <= ent_i.dx;
      dy_q <= ent_i.dy;
    end
    if (state_q == S_MULT) begin
      p_xc_q <= dx_q * $signed(ctrl_i.cos_angle);
      p_ys_q <= dy_q * $signed(ctrl_i.sin_angle);
      p_xs_q <= dx_q * $signed(ctrl_i.sin_angle);
      p_yc_q <= dy_q * $signed(ctrl_i.cos_angle);
    end
    if (state_q == S_SUM) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
    if (state_q == S_ROUND) begin
      oob_q     <= !in_img;
      rd_addr_q <= rd_addr_d;
    end
    if (out_load) begin
      out_q.blue_out      <= color_sel[CHAN_W-1:0];
      out_q.green_out     <= color_sel[2*CHAN_W-1:CHAN_W];
      out_q.red_out       <= color_sel[3*CHAN_W-1:2*CHAN_W];
      out_q.out_of_bounds <= oob_q;
    end
  end

  // Frame store: one write port for loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= ent_i.color;
    end
    if (state_q == S_READ) begin
      rd_data_q <= frame_mem[rd_addr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `IRN_ASSERT(a_bk_oob_black, clk_i, rst_ni, out_valid_o && out_word_o.out_of_bounds |-> {out_word_o.blue_out, out_word_o.green_out, out_word_o.red_out} == '0)
  `IRN_ASSERT(a_bk_emit_hold, clk_i, rst_ni, state_q == S_EMIT && out_valid_q && !out_ready_i |=> state_q == S_EMIT)
  `IRN_ASSERT(a_bk_rise_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == S_EMIT)

endmodule

`default_nettype wire

FILE: rtl/image_rotate_nearest.sv
// Channel | Role   | Word                                   | Handshake
// in_i    | sink   | operation, pixel_x/y, blue/green/red_in | valid && ready
// out_o   | source | blue/green/red_out, out_of_bounds       | valid && ready
// cfg_i   | sink   | reg_index, wdata                        | valid (ready tied high)
//
// A load word is written to the frame store as it is popped; the back end stays
// ready for the next word. A produce word is stepped by the single sequencer
// through pop, multiply, sum, round, store read and emit; no new word is taken
// until emit has loaded the output register. The front stage and a two-word queue
// keep accepting while the back end works or while a result waits in the output
// register, until both are full. Reset restores the configuration registers and
// control state; the frame store is not cleared and holds garbage until loaded.
`default_nettype none

module image_rotate_nearest import irn_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  irn_pix_if.sink   in_i,
  irn_res_if.source out_o,
  irn_cfg_if.sink   cfg_i
);

  // Configuration registers
  logic [SIZE_W-1:0]         width_q;
  logic [SIZE_W-1:0]         height_q;
  logic signed [ANGLE_W-1:0] cos_q;
  logic signed [ANGLE_W-1:0] sin_q;
  ctrl_t                     ctrl;

  // Front to queue
  logic  push_valid, push_ready;
  qent_t push_ent;
  // Queue to back
  logic  pop_valid, pop;
  qent_t pop_ent;

  // Config writes are always accepted; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      cos_q    <= RST_COS;
      sin_q    <= RST_SIN;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.reg_index)
        REG_WIDTH:  width_q  <= cfg_i.payload.wdata[SIZE_W-1:0];
        REG_HEIGHT: height_q <= cfg_i.payload.wdata[SIZE_W-1:0];
        REG_COS:    cos_q    <= $signed(cfg_i.payload.wdata[ANGLE_W-1:0]);
        REG_SIN:    sin_q    <= $signed(cfg_i.payload.wdata[ANGLE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Clamp the image size to the frame store
  always_comb begin
    ctrl.eff_w     = (32'(width_q) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : width_q;
    ctrl.eff_h     = (32'(height_q) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : height_q;
    ctrl.cos_angle = cos_q;
    ctrl.sin_angle = sin_q;
  end

  // Front: accept, classify, compute center offsets
  irn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_word_i    (in_i.payload),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ent_o   (push_ent)
  );

  // Short queue decoupling front and back
  irn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_ent_i   (push_ent),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_ent_o    (pop_ent)
  );

  // Back: frame store writes, inverse rotation, sampling, output register
  irn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .ent_i       (pop_ent),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.payload)
  );

endmodule

`default_nettype wire

FILE: sim/image_rotate_nearest_tb.sv
`timescale 1ns / 100ps

module image_rotate_nearest_tb;
  import irn_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_WORDS   = 64;
  localparam longint      Q_ONE         = 16384;
  localparam longint      Q_DIV         = 32768;
  // Indexes that decode to no register; writes to them must be dropped.
  localparam logic [IDX_W-1:0] REG_SPARE = 8'd7;
  localparam logic [IDX_W-1:0] REG_TOP   = 8'hFF;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  // One line of the directed table: either a pixel word or a register write.
  // Produce words with a typed-in answer carry it in want ({blue, green, red, oob}).
  typedef struct {
    row_kind_e kind;
    pix_in_t   word;
    cfg_wr_t   wr;
    bit        fixed;
    res_t      want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  irn_pix_if pix_if ();
  irn_res_if res_if ();
  irn_cfg_if cfg_if ();

  image_rotate_nearest dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the registers and the frame store, advanced on every accepted word.
  logic [SIZE_W-1:0]         size_w;
  logic [SIZE_W-1:0]         size_h;
  logic signed [ANGLE_W-1:0] cos_q;
  logic signed [ANGLE_W-1:0] sin_q;
  logic [COLOR_W-1:0]        frame_copy [FRAME_WORDS];
  bit                        loaded [FRAME_WORDS];

  res_t      awaited_pixels [$];
  stim_row_t stim_rows [$];

  int unsigned err_count   = 0;
  int unsigned n_loads     = 0;
  int unsigned n_produces  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_writes    = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 30;
  int unsigned out_stall   = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Round a Q.15 source coordinate to the nearest integer, ties to even.
  function automatic longint round_q15(input longint n);
    longint q, r;
    if (n >= 0) begin
      q = n / Q_DIV;
    end else begin
      q = -((-n + Q_DIV - 1) / Q_DIV);
    end
    r = n - q * Q_DIV;
    if (r > Q_DIV / 2 || (r == Q_DIV / 2 && q[0])) begin
      q = q + 1;
    end
    return q;
  endfunction

  // Inverse-map an output coordinate to its source coordinate under the live settings.
  function automatic void map_source(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                     output longint sx, output longint sy, output bit hit);
    longint w, h, dx, dy;
    w  = (size_w > MAX_WIDTH) ? longint'(MAX_WIDTH) : longint'(size_w);
    h  = (size_h > MAX_HEIGHT) ? longint'(MAX_HEIGHT) : longint'(size_h);
    dx = 2 * longint'(x) - w;
    dy = 2 * longint'(y) - h;
    sx = round_q15(dx * longint'(cos_q) + dy * longint'(sin_q) + w * Q_ONE);
    sy = round_q15(-dx * longint'(sin_q) + dy * longint'(cos_q) + h * Q_ONE);
    hit = sx >= 0 && sx < w && sy >= 0 && sy < h;
  endfunction

  function automatic res_t rotate_sample(input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y);
    longint             sx, sy;
    bit                 hit;
    res_t               res;
    logic [COLOR_W-1:0] c;
    map_source(x, y, sx, sy, hit);
    res = '0;
    if (hit) begin
      c = frame_copy[sy * MAX_WIDTH + sx];
      res.blue_out  = c[7:0];
      res.green_out = c[15:8];
      res.red_out   = c[23:16];
    end
    res.out_of_bounds = !hit;
    return res;
  endfunction

  // idle_pct sets how often a gap comes; most gaps are short, a few are long.
  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) begin
      return 0;
    end
    if ($urandom_range(9) < 8) begin
      return int'($urandom_range(3, 1));
    end
    return int'($urandom_range(40, 8));
  endfunction

  // Size value with random junk above the nine register bits.
  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int unsigned sel, val;
    sel = $urandom_range(19);
    if (sel == 0) begin
      val = 0;
    end else if (sel < 3) begin
      val = $urandom_range(511, 257);
    end else if (sel < 6) begin
      val = $urandom_range(4, 1);
    end else if (sel < 10) begin
      val = 256;
    end else begin
      val = $urandom_range(256, 1);
    end
    return {7'($urandom), 9'(val)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_angle();
    if ($urandom_range(9) < 2) begin
      case ($urandom_range(4))
        0: return 16'sd16384;
        1: return -16'sd16384;
        2: return 16'sd0;
        3: return 16'sh7FFF;
        default: return 16'sh8000;
      endcase
    end
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic void add_word(input op_e op, input logic [7:0] x, input logic [7:0] y,
                                   input logic [23:0] bgr);
    stim_row_t r;
    r.kind  = ROW_WORD;
    r.word  = {op, x, y, bgr};
    r.wr    = '0;
    r.fixed = 1'b0;
    r.want  = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_probe(input logic [7:0] x, input logic [7:0] y,
                                    input logic [23:0] bgr, input logic oob);
    stim_row_t r;
    r.kind  = ROW_WORD;
    r.word  = {OP_PRODUCE, x, y, 24'h000000};
    r.wr    = '0;
    r.fixed = 1'b1;
    r.want  = {bgr, oob};
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.word  = '0;
    r.wr    = {idx, data};
    r.fixed = 1'b0;
    r.want  = '0;
    stim_rows.push_back(r);
  endfunction

  // Drive one word at the falling edge, hold it until accepted, then advance the shadow state.
  task automatic send_word(input pix_in_t w, input bit fixed, input res_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid   = 1'b1;
    pix_if.payload = w;
    do begin
      @(posedge clk_i);
    end while (!pix_if.ready);
    if (w.operation == OP_LOAD) begin
      frame_copy[{w.pixel_y, w.pixel_x}] = {w.red_in, w.green_in, w.blue_in};
      loaded[{w.pixel_y, w.pixel_x}]     = 1'b1;
      n_loads++;
    end else begin
      awaited_pixels.push_back(fixed ? want : rotate_sample(w.pixel_x, w.pixel_y));
      n_produces++;
    end
  endtask

  // A produce that would hit a never-loaded store entry is preceded by a load of that
  // entry, so the block never reads garbage.
  task automatic issue_word(input pix_in_t w, input bit fixed, input res_t want);
    longint  sx, sy;
    bit      hit;
    pix_in_t fill;
    if (w.operation == OP_PRODUCE) begin
      map_source(w.pixel_x, w.pixel_y, sx, sy, hit);
      if (hit && !loaded[sy * MAX_WIDTH + sx]) begin
        fill.operation = OP_LOAD;
        fill.pixel_x   = sx[7:0];
        fill.pixel_y   = sy[7:0];
        fill.blue_in   = 8'($urandom);
        fill.green_in  = 8'($urandom);
        fill.red_in    = 8'($urandom);
        send_word(fill, 1'b0, '0);
      end
    end
    send_word(w, fixed, want);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid             = 1'b1;
    cfg_if.payload.reg_index = idx;
    cfg_if.payload.wdata     = data;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    case (idx)
      REG_WIDTH:  size_w = data[SIZE_W-1:0];
      REG_HEIGHT: size_h = data[SIZE_W-1:0];
      REG_COS:    cos_q  = data;
      REG_SIN:    sin_q  = data;
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Drop valid, wait for every pending pixel, then let trailing loads retire.
  task automatic wait_idle();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  // Hard stop on a hang.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stall at random, compare each accepted word with the oldest prediction.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_stall > 0) begin
        res_if.ready = 1'b0;
        out_stall--;
      end else begin
        res_if.ready = 1'b1;
        out_stall    = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : pixel_check
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_pixels.size() == 0) begin
        err_count++;
        $display("%0t: pixel with none pending, expected nothing actual %p",
                 $time, res_if.payload);
      end else begin
        want = awaited_pixels.pop_front();
        check_field("blue_out", want.blue_out, res_if.payload.blue_out);
        check_field("green_out", want.green_out, res_if.payload.green_out);
        check_field("red_out", want.red_out, res_if.payload.red_out);
        check_field("out_of_bounds", 8'(want.out_of_bounds),
                    8'(res_if.payload.out_of_bounds));
        n_checked++;
      end
    end
  end

  initial begin : stimulus
    pix_in_t     w;
    int unsigned frame_w, frame_h;

    rst_ni         = 1'b0;
    pix_if.valid   = 1'b0;
    pix_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    size_w         = RST_WIDTH;
    size_h         = RST_HEIGHT;
    cos_q          = RST_COS;
    sin_q          = RST_SIN;

    // Reset leaves an identity mapping on a full 256x256 frame: each corner reads itself.
    add_word(OP_LOAD, 8'd0, 8'd0, 24'h000000);
    add_word(OP_LOAD, 8'd255, 8'd255, 24'hFFFFFF);
    add_word(OP_LOAD, 8'd255, 8'd0, 24'hA55AC3);
    add_word(OP_LOAD, 8'd0, 8'd255, 24'h5AA53C);
    add_probe(8'd0, 8'd0, 24'h000000, 1'b0);
    add_probe(8'd255, 8'd255, 24'hFFFFFF, 1'b0);
    add_probe(8'd255, 8'd0, 24'hA55AC3, 1'b0);
    add_probe(8'd0, 8'd255, 24'h5AA53C, 1'b0);
    // Zero width: everything falls outside and comes back black.
    add_cfg(REG_WIDTH, 16'h0000);
    add_probe(8'd128, 8'd128, 24'h000000, 1'b1);
    // Width above the store clamps to the store width.
    add_cfg(REG_WIDTH, 16'hFFFF);
    add_probe(8'd255, 8'd255, 24'hFFFFFF, 1'b0);
    // Writes to unused indexes must leave the mapping alone.
    add_cfg(REG_SPARE, 16'h1234);
    add_cfg(REG_TOP, 16'hFFFF);
    add_probe(8'd0, 8'd255, 24'h5AA53C, 1'b0);
    // Small frame: a produce outside the image maps outside and is black.
    add_cfg(REG_WIDTH, 16'd4);
    add_cfg(REG_HEIGHT, 16'd4);
    add_probe(8'd5, 8'd5, 24'h000000, 1'b1);
    add_probe(8'd0, 8'd0, 24'h000000, 1'b0);
    // Half turn on the 4x4 frame.
    add_cfg(REG_COS, 16'hC000);
    add_probe(8'd0, 8'd0, 24'h000000, 1'b1);
    add_word(OP_PRODUCE, 8'd1, 8'd2, 24'h000000);
    // Half-scale mirror on a 2x2 frame: hits exact halves, negative and positive.
    add_cfg(REG_WIDTH, 16'd2);
    add_cfg(REG_HEIGHT, 16'd2);
    add_cfg(REG_COS, 16'hE000);
    add_word(OP_PRODUCE, 8'd4, 8'd4, 24'h000000);
    add_word(OP_PRODUCE, 8'd1, 8'd0, 24'h000000);
    // Quarter turn on the full frame.
    add_cfg(REG_WIDTH, 16'd256);
    add_cfg(REG_HEIGHT, 16'd256);
    add_cfg(REG_COS, 16'h0000);
    add_cfg(REG_SIN, 16'h4000);
    add_word(OP_PRODUCE, 8'd10, 8'd200, 24'h000000);
    add_word(OP_PRODUCE, 8'd255, 8'd0, 24'h000000);
    // Raw extremes of the angle registers, beyond unit range.
    add_cfg(REG_COS, 16'h7FFF);
    add_cfg(REG_SIN, 16'h8000);
    add_word(OP_PRODUCE, 8'd128, 8'd128, 24'h000000);
    add_word(OP_PRODUCE, 8'd0, 8'd0, 24'h000000);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table; register writes only once the block has gone quiet.
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(stim_rows[i].wr.reg_index, stim_rows[i].wr.wdata);
      end else begin
        issue_word(stim_rows[i].word, stim_rows[i].fixed, stim_rows[i].want);
      end
    end

    // Random phases: new size and angle each time, idling varied from none to heavy.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      idle_pct = (p % 3 == 1) ? 0 : ((p % 3 == 0) ? 25 : 60);
      write_reg(REG_WIDTH, pick_size());
      write_reg(REG_HEIGHT, pick_size());
      write_reg(REG_COS, pick_angle());
      write_reg(REG_SIN, pick_angle());
      if ($urandom_range(3) == 0) begin
        write_reg(8'($urandom_range(255, 4)), 16'($urandom));
      end
      frame_w = (size_w > MAX_WIDTH) ? MAX_WIDTH : size_w;
      frame_h = (size_h > MAX_HEIGHT) ? MAX_HEIGHT : size_h;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w.operation = ($urandom_range(99) < 55) ? OP_PRODUCE : OP_LOAD;
        // Keep most coordinates inside the image, the rest anywhere in the store.
        if (frame_w > 0 && frame_h > 0 && $urandom_range(99) < 80) begin
          w.pixel_x = 8'($urandom_range(frame_w - 1));
          w.pixel_y = 8'($urandom_range(frame_h - 1));
        end else begin
          w.pixel_x = 8'($urandom);
          w.pixel_y = 8'($urandom);
        end
        w.blue_in  = 8'($urandom);
        w.green_in = 8'($urandom);
        w.red_in   = 8'($urandom);
        issue_word(w, 1'b0, '0);
        // Now and then hold the sender until the output side has caught up.
        if ($urandom_range(199) == 0) begin
          wait_idle();
        end
      end
    end

    wait_idle();
    $display("tb: %0d loads, %0d produces, %0d pixels compared, %0d register writes",
             n_loads, n_produces, n_checked, n_writes);
    $display("tb: identity, half and quarter turns, rounding ties, clamped and empty frames");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: image_rotate_nearest.f
+incdir+rtl
rtl/irn_pkg.sv
rtl/irn_channels_if.sv
rtl/irn_queue.sv
rtl/irn_front.sv
rtl/irn_back.sv
rtl/image_rotate_nearest.sv
sim/image_rotate_nearest_tb.sv
